// ===== design/schroeder_allpass_cascade_defines.svh =====
// Assertion macros shared by the allpass cascade RTL.
`ifndef SCHROEDER_ALLPASS_CASCADE_DEFINES_SVH
`define SCHROEDER_ALLPASS_CASCADE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only out of reset
`define SAC_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included
`define SAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAC_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define SAC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/sac_pkg.sv =====
// Shared types and constants of the allpass cascade.
package sac_pkg;

    // Structure of the cascade
    localparam int STAGES          = 3;
    localparam int MAX_DELAY_DEF   = 65536;
    localparam int SAMPLE_BITS_DEF = 24;

    // Register field widths
    localparam int GAIN_BITS     = 16;
    localparam int CNT_BITS      = 2;
    localparam int LEN_BITS      = 17;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 17;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN          = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_STAGE_COUNT   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_LENGTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_LENGTH = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_THIRD_LENGTH  = 3'd4;

    // Reset values
    localparam logic signed [GAIN_BITS-1:0] GAIN_RST   = 16'sd22938;
    localparam logic [CNT_BITS-1:0]         COUNT_RST  = 2'd3;
    localparam logic [LEN_BITS-1:0]         LEN0_RST   = 17'd33312;
    localparam logic [LEN_BITS-1:0]         LEN1_RST   = 17'd10848;
    localparam logic [LEN_BITS-1:0]         LEN2_RST   = 17'd3552;

    // Settings seen by one cell
    typedef struct packed {
        logic                        active;
        logic signed [GAIN_BITS-1:0] gain;
        logic [LEN_BITS-1:0]         length;
    } cell_cfg_t;

endpackage

// ===== design/sac_cell.sv =====
// One allpass cell: delay memory, position, shared multiplier and output register.
module sac_cell #(
    parameter int MAX_DELAY   = sac_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = sac_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sac_pkg::cell_cfg_t            cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_data
);

    localparam int SW       = SAMPLE_BITS;
    localparam int PW       = SW + sac_pkg::GAIN_BITS;
    localparam int POS_BITS = $clog2(MAX_DELAY);
    localparam int CW       = (sac_pkg::LEN_BITS > POS_BITS + 1) ?
                              sac_pkg::LEN_BITS : POS_BITS + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MUL1  = 3'd2;
    localparam logic [2:0] ST_SUBW  = 3'd3;
    localparam logic [2:0] ST_MUL2  = 3'd4;
    localparam logic [2:0] ST_ADDY  = 3'd5;
    localparam logic [2:0] ST_PASS  = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [POS_BITS-1:0]     clr_cnt_reg;
    logic [POS_BITS-1:0]     pos_reg;
    logic [POS_BITS-1:0]     addr_reg;
    logic signed [SW-1:0]    x_reg, d_reg, w_reg, rd_data_reg;
    logic signed [PW-1:0]    prod_reg;
    logic                    out_valid_reg;
    logic signed [SW-1:0]    out_data_reg;

    logic signed [SW-1:0]    mem [0:MAX_DELAY-1];
    logic                    mem_we;
    logic [POS_BITS-1:0]     mem_waddr;
    logic signed [SW-1:0]    mem_wdata;

    logic [CW-1:0]           len_ext;
    logic [POS_BITS-1:0]     last_idx, eff_pos;
    logic signed [SW-1:0]    mul_op;
    logic signed [PW-1:0]    mul_prod;
    logic signed [SW:0]      prod_sh;
    logic signed [SW+1:0]    w_sum, y_sum;
    logic                    accept, slot_free;

    // Clamp a sum to the sample range
    function automatic logic signed [SW-1:0] sat_sw(input logic signed [SW+1:0] v);
        logic signed [SW-1:0] r;
        if (v[SW+1] && !(&v[SW:SW-1])) begin
            r = {1'b1, {(SW-1){1'b0}}};
        end else if (!v[SW+1] && (|v[SW:SW-1])) begin
            r = {1'b0, {(SW-1){1'b1}}};
        end else begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    // Effective last index and clamped position
    always_comb begin
        len_ext = CW'(cfg.length);
        if (len_ext == '0) begin
            last_idx = '0;
        end else if (len_ext > CW'(MAX_DELAY)) begin
            last_idx = POS_BITS'(MAX_DELAY - 1);
        end else begin
            last_idx = POS_BITS'(len_ext - CW'(1));
        end
        eff_pos = (pos_reg > last_idx) ? last_idx : pos_reg;
    end

    // Shared multiplier and the two saturating sums
    assign mul_op   = (state_reg == ST_MUL1) ? rd_data_reg : w_reg;
    assign mul_prod = PW'(cfg.gain) * PW'(mul_op);
    assign prod_sh  = prod_reg[PW-1:15];
    assign w_sum    = (SW+2)'(x_reg) - (SW+2)'(prod_sh);
    assign y_sum    = (SW+2)'(prod_sh) + (SW+2)'(d_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg) inside
            ST_CLEAR: begin
                if (clr_cnt_reg == POS_BITS'(MAX_DELAY - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = cfg.active ? ST_MUL1 : ST_PASS;
                end
            end
            ST_MUL1: state_next = ST_SUBW;
            ST_SUBW: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_ADDY;
            ST_ADDY, ST_PASS: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory write: clearing sweep or the new w
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = w_reg;
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else if (state_reg == ST_MUL2) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[eff_pos];
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == ST_MUL2) begin
                pos_reg <= (addr_reg == '0) ? last_idx : addr_reg - 1'b1;
            end
            if ((state_reg == ST_ADDY || state_reg == ST_PASS) && slot_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg    <= in_data;
            addr_reg <= eff_pos;
        end
        if (state_reg == ST_MUL1) begin
            d_reg <= rd_data_reg;
        end
        if (state_reg == ST_MUL1 || state_reg == ST_MUL2) begin
            prod_reg <= mul_prod;
        end
        if (state_reg == ST_SUBW) begin
            w_reg <= sat_sw(w_sum);
        end
        if (state_reg == ST_ADDY && slot_free) begin
            out_data_reg <= sat_sw(y_sum);
        end else if (state_reg == ST_PASS && slot_free) begin
            out_data_reg <= x_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/schroeder_allpass_cascade.sv =====
// Top level: register file and a chain of three allpass cells.
// Active cells run each beat through the MUL1, SUBW, MUL2 and ADDY states; unused cells pass it on unchanged.
// A cell takes a new beat only once its read, two multiplies and sums are done and its result is registered.
// Cells in the chain work on different beats at once.
// Reset: registers take their defaults; each cell then clears its MAX_DELAY-word
// delay memory, one word a cycle, with s_ready low until the clear is done.
`include "schroeder_allpass_cascade_defines.svh"
module schroeder_allpass_cascade #(
    parameter int MAX_DELAY   = sac_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = sac_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sac_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [sac_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_BITS-1:0]       m_sample_out
);

    localparam int N = sac_pkg::STAGES;

    logic signed [sac_pkg::GAIN_BITS-1:0] gain_reg;
    logic [sac_pkg::CNT_BITS-1:0]         stage_count_reg;
    logic [sac_pkg::LEN_BITS-1:0]         length_reg [0:N-1];

    logic                          link_valid [0:N];
    logic                          link_ready [0:N];
    logic signed [SAMPLE_BITS-1:0] link_data  [0:N];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg        <= sac_pkg::GAIN_RST;
            stage_count_reg <= sac_pkg::COUNT_RST;
            length_reg[0]   <= sac_pkg::LEN0_RST;
            length_reg[1]   <= sac_pkg::LEN1_RST;
            length_reg[2]   <= sac_pkg::LEN2_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sac_pkg::REG_GAIN:
                    gain_reg <= cfg_wr_data[sac_pkg::GAIN_BITS-1:0];
                sac_pkg::REG_STAGE_COUNT:
                    stage_count_reg <= cfg_wr_data[sac_pkg::CNT_BITS-1:0];
                sac_pkg::REG_FIRST_LENGTH:
                    length_reg[0] <= cfg_wr_data[sac_pkg::LEN_BITS-1:0];
                sac_pkg::REG_SECOND_LENGTH:
                    length_reg[1] <= cfg_wr_data[sac_pkg::LEN_BITS-1:0];
                sac_pkg::REG_THIRD_LENGTH:
                    length_reg[2] <= cfg_wr_data[sac_pkg::LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Chain ends
    assign link_valid[0] = s_valid;
    assign link_data[0]  = s_sample_in;
    assign s_ready       = link_ready[0];
    assign m_valid       = link_valid[N];
    assign m_sample_out  = link_data[N];
    assign link_ready[N] = m_ready;

    // Cell chain
    for (genvar k = 0; k < N; k++) begin : g_cell
        sac_pkg::cell_cfg_t cell_cfg;

        assign cell_cfg.active = (sac_pkg::CNT_BITS'(k) < stage_count_reg);
        assign cell_cfg.gain   = gain_reg;
        assign cell_cfg.length = length_reg[k];

        sac_cell #(
            .MAX_DELAY   (MAX_DELAY),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cfg       (cell_cfg),
            .in_valid  (link_valid[k]),
            .in_ready  (link_ready[k]),
            .in_data   (link_data[k]),
            .out_valid (link_valid[k+1]),
            .out_ready (link_ready[k+1]),
            .out_data  (link_data[k+1])
        );
    end

    // Checks
    `SAC_ASSERT_ALWAYS(a_no_out_after_reset, aclk, !aresetn |=> !m_valid, "output beat right after reset")
    `SAC_ASSERT_ALWAYS(a_clear_blocks_input, aclk, !aresetn |=> !s_ready, "input taken before memory clear")
    `SAC_ASSERT_RST(a_one_beat_per_cell, aclk, aresetn, s_valid && s_ready |=> !s_ready, "first cell took two beats back to back")

endmodule
